// ----- sv/nbu_pkg.sv -----
package nbu_pkg;

  localparam int unsigned MaxElementBytes = 8;
  localparam int unsigned ElementW        = 64;
  localparam int unsigned BytesW          = 4;
  localparam int unsigned TopW            = 6;
  localparam int unsigned LenW            = 7;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned CfgDataW        = 7;
  localparam int unsigned AccW            = 63;
  localparam int unsigned HeldW           = 6;

  localparam logic [BytesW-1:0] ResetElementBytes = 4'd4;
  localparam logic [TopW-1:0]   ResetFieldTopBit  = 6'd31;
  localparam logic [LenW-1:0]   ResetFieldLength  = 7'd32;
  localparam logic [LenW-1:0]   MaxFieldLength    = 7'd64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgElementBytes = 3'd0,
    CfgFieldTopBit  = 3'd1,
    CfgFieldLength  = 3'd2,
    CfgFillOnes     = 3'd3,
    CfgSignExtend   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [BytesW-1:0] elem_bytes;
    logic [TopW-1:0]   top_bit;
    logic [LenW-1:0]   field_len;
    logic              fill_ones;
    logic              sext_en;
  } cfg_t;

  typedef struct packed {
    logic [7:0] stream_byte;
  } in_item_t;

  typedef struct packed {
    logic [ElementW-1:0] element_value;
    logic                last_of_byte;
  } out_item_t;

  typedef struct packed {
    logic [ElementW-1:0] field;
    logic                last;
  } emit_t;

  // mask of the n low bits, n up to 64
  function automatic logic [ElementW-1:0] low_ones(logic [LenW-1:0] n);
    low_ones = (64'd1 << n) - 64'd1;
  endfunction

  // move a value of len bits so that its msb sits at bit top
  function automatic logic [ElementW-1:0] place_bits(logic [ElementW-1:0] v,
                                                      logic [LenW-1:0] len,
                                                      logic [TopW-1:0] top);
    logic signed [7:0] bot;
    logic [7:0]        neg;
    bot = $signed({2'b00, top}) - $signed({1'b0, len}) + 8'sd1;
    neg = 8'(-bot);
    if (bot >= 0) begin
      place_bits = v << bot[5:0];
    end else begin
      place_bits = v >> neg[5:0];
    end
  endfunction

  function automatic logic [ElementW-1:0] build_element(logic [ElementW-1:0] value,
                                                         cfg_t cfg);
    logic [ElementW-1:0] lmask;
    logic [ElementW-1:0] vm;
    logic [ElementW-1:0] fmask;
    logic [ElementW-1:0] e;
    logic [ElementW-1:0] upper;
    logic [LenW-1:0]     nbits;
    logic                sign;
    lmask = low_ones(cfg.field_len);
    vm    = value & lmask;
    fmask = place_bits(lmask, cfg.field_len, cfg.top_bit);
    e     = cfg.fill_ones ? ~fmask : '0;
    e     = e | place_bits(vm, cfg.field_len, cfg.top_bit);
    nbits = {cfg.elem_bytes, 3'b000};
    upper = ~low_ones({1'b0, cfg.top_bit});
    sign  = vm[6'(cfg.field_len - 7'd1)];
    if (cfg.sext_en && ({1'b0, cfg.top_bit} < nbits)) begin
      e = sign ? (e | upper) : (e & ~upper);
    end
    build_element = e & low_ones(nbits);
  endfunction

endpackage

// ----- sv/nbu_chan_if.sv -----
interface nbu_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/nbu_cfg_regs.sv -----
module nbu_cfg_regs #(
  parameter int unsigned MAX_ELEMENT_BYTES = nbu_pkg::MaxElementBytes
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [nbu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nbu_pkg::CfgDataW-1:0] cfg_data_i,
  output nbu_pkg::cfg_t                cfg_o
);
  import nbu_pkg::*;

  function automatic logic [BytesW-1:0] clamp_bytes(logic [BytesW-1:0] v);
    logic [BytesW-1:0] r;
    priority if (v == '0) begin
      r = 4'd1;
    end else if (v > BytesW'(MAX_ELEMENT_BYTES)) begin
      r = BytesW'(MAX_ELEMENT_BYTES);
    end else begin
      r = v;
    end
    clamp_bytes = r;
  endfunction

  function automatic logic [LenW-1:0] clamp_len(logic [LenW-1:0] v);
    logic [LenW-1:0] r;
    priority if (v == '0) begin
      r = 7'd1;
    end else if (v > MaxFieldLength) begin
      r = MaxFieldLength;
    end else begin
      r = v;
    end
    clamp_len = r;
  endfunction

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.elem_bytes <= clamp_bytes(ResetElementBytes);
      cfg_q.top_bit    <= ResetFieldTopBit;
      cfg_q.field_len  <= ResetFieldLength;
      cfg_q.fill_ones  <= 1'b0;
      cfg_q.sext_en    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgElementBytes: cfg_q.elem_bytes <= clamp_bytes(cfg_data_i[BytesW-1:0]);
        CfgFieldTopBit:  cfg_q.top_bit    <= cfg_data_i[TopW-1:0];
        CfgFieldLength:  cfg_q.field_len  <= clamp_len(cfg_data_i[LenW-1:0]);
        CfgFillOnes:     cfg_q.fill_ones  <= cfg_data_i[0];
        CfgSignExtend:   cfg_q.sext_en    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/nbu_gather.sv -----
module nbu_gather (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  nbu_pkg::cfg_t  cfg_i,
  nbu_chan_if.sink       in_i,
  output logic           emit_valid_o,
  output nbu_pkg::emit_t emit_o,
  input  logic           emit_ready_i
);
  import nbu_pkg::*;

  logic             byte_vld_q, byte_vld_d;
  logic [7:0]       byte_q;
  logic [2:0]       pos_q, pos_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [HeldW-1:0] held_q, held_d;

  logic [7:0]          rem;
  logic [7:0]          rest;
  logic [7:0]          chunk;
  logic [7:0]          tail;
  logic [3:0]          rcnt;
  logic [3:0]          need_n;
  logic [3:0]          left;
  logic [LenW-1:0]     held_ext;
  logic [LenW-1:0]     need;
  logic [ElementW-1:0] absorb;
  logic                hit;
  logic                last;
  logic                adv;
  logic                done;
  logic                take;

  // bits of the current byte not yet consumed, left aligned
  assign rem      = byte_q << pos_q;
  assign rcnt     = 4'd8 - {1'b0, pos_q};
  assign held_ext = {1'b0, held_q};
  assign need     = (held_ext >= cfg_i.field_len) ? 7'd1 : (cfg_i.field_len - held_ext);
  assign hit      = byte_vld_q && (need <= {3'b000, rcnt});
  assign need_n   = need[3:0];
  assign chunk    = rem >> (4'd8 - need_n);
  assign rest     = rem << need_n;
  assign left     = rcnt - need_n;
  assign tail     = rest >> (4'd8 - left);
  assign last     = {3'b000, left} < cfg_i.field_len;
  assign absorb   = ({1'b0, acc_q} << rcnt) | ElementW'(rem >> (4'd8 - rcnt));

  assign adv  = byte_vld_q && (!hit || emit_ready_i);
  assign done = adv && (!hit || last);
  assign take = in_i.valid && in_i.ready;

  assign in_i.ready   = !byte_vld_q || done;
  assign emit_valid_o = hit;
  assign emit_o.field = ({1'b0, acc_q} << need_n) | ElementW'(chunk);
  assign emit_o.last  = last;

  always_comb begin
    acc_d      = acc_q;
    held_d     = held_q;
    pos_d      = pos_q;
    byte_vld_d = byte_vld_q;
    if (adv) begin
      if (hit) begin
        pos_d = pos_q + need[2:0];
        if (last) begin
          acc_d  = AccW'(tail);
          held_d = HeldW'(left);
        end else begin
          acc_d  = '0;
          held_d = '0;
        end
      end else begin
        acc_d  = absorb[AccW-1:0];
        held_d = held_q + HeldW'(rcnt);
      end
    end
    if (done) begin
      byte_vld_d = 1'b0;
    end
    if (take) begin
      byte_vld_d = 1'b1;
      pos_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
      pos_q      <= '0;
      acc_q      <= '0;
      held_q     <= '0;
    end else begin
      byte_vld_q <= byte_vld_d;
      pos_q      <= pos_d;
      acc_q      <= acc_d;
      held_q     <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= in_i.data.stream_byte;
    end
  end

  // a held-off element keeps its value until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_valid_o && !emit_ready_i) |=> (emit_valid_o && $stable(emit_o.field)))
    else $error("stalled element changed");

  // an element that is not the last of its byte leaves the byte in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_valid_o && emit_ready_i && !emit_o.last) |=> (byte_vld_q && (pos_q != '0)))
    else $error("byte dropped before its last element");

  // a new byte only enters once the old one is fully consumed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && byte_vld_q) |-> (done && (!hit || last)))
    else $error("byte overwritten while still in use");

endmodule

// ----- sv/nbu_elem_build.sv -----
module nbu_elem_build #(
  parameter int unsigned MAX_ELEMENT_BYTES = nbu_pkg::MaxElementBytes
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  nbu_pkg::cfg_t  cfg_i,
  input  logic           emit_valid_i,
  input  nbu_pkg::emit_t emit_i,
  output logic           emit_ready_o,
  nbu_chan_if.source     out_o
);
  import nbu_pkg::*;

  localparam int unsigned ElemW = 8 * MAX_ELEMENT_BYTES;

  logic                out_vld_q;
  logic [ElemW-1:0]    elem_q;
  logic                last_q;
  logic [ElementW-1:0] element;
  logic                load;

  assign element      = build_element(emit_i.field, cfg_i);
  assign emit_ready_o = !out_vld_q || out_o.ready;
  assign load         = emit_valid_i && emit_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      elem_q <= element[ElemW-1:0];
      last_q <= emit_i.last;
    end
  end

  assign out_o.valid              = out_vld_q;
  assign out_o.data.element_value = ElementW'(elem_q);
  assign out_o.data.last_of_byte  = last_q;

  // bits above the configured element size stay clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((ElementW'(elem_q) >> {cfg_i.elem_bytes, 3'b000}) == '0))
    else $error("element bits set above element size");

endmodule

// ----- sv/nbit_field_unpacker.sv -----
// channel  dir  payload                         transaction
// in_i     in   stream_byte[7:0]                valid && ready
// out_o    out  element_value[63:0], last_of_byte valid && ready
// cfg      in   cfg_idx_i, cfg_data_i[6:0]      cfg_we_i
//
// a byte stays until all n elements it completes (0..8) have left the gather stage
// one element per cycle moves from gather to the output register unless it is held full
// reset clears the gathered bits and loads the default configuration
// out_o.ready low holds the output register and, once full, a byte that completes an element

module nbit_field_unpacker #(
  parameter int unsigned MAX_ELEMENT_BYTES = nbu_pkg::MaxElementBytes
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [nbu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nbu_pkg::CfgDataW-1:0] cfg_data_i,
  nbu_chan_if.sink                     in_i,
  nbu_chan_if.source                   out_o
);
  import nbu_pkg::*;

  cfg_t  cfg;
  emit_t emit;
  logic  emit_valid;
  logic  emit_ready;

  nbu_cfg_regs #(
    .MAX_ELEMENT_BYTES(MAX_ELEMENT_BYTES)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  nbu_gather u_gather (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .emit_valid_o(emit_valid),
    .emit_o      (emit),
    .emit_ready_i(emit_ready)
  );

  nbu_elem_build #(
    .MAX_ELEMENT_BYTES(MAX_ELEMENT_BYTES)
  ) u_build (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .emit_valid_i(emit_valid),
    .emit_i      (emit),
    .emit_ready_o(emit_ready),
    .out_o       (out_o)
  );

endmodule

// ----- tb/nbit_field_unpacker_tb.sv -----
`timescale 1ns / 1ps

module nbit_field_unpacker_tb;
  import nbu_pkg::*;

  localparam int Limit = 200000;
  localparam int PlanLen = 46;
  localparam int RandPhases = 9;
  localparam int BytesPerPhase = 23;

  typedef struct packed {
    logic          is_cfg;
    cfg_idx_e      idx;
    logic [7:0]    val;
    logic          typed;
    logic [63:0]   want;
  } step_t;

  typedef struct packed {
    logic [7:0]  value;
    logic        typed;
    logic [63:0] want;
  } feed_t;

  localparam step_t Plan [PlanLen] = '{
    '{1'b0, CfgElementBytes, 8'hFF, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'hFF, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'hFF, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'hFF, 1'b1, 64'h0000_0000_FFFF_FFFF},
    '{1'b0, CfgElementBytes, 8'h00, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'h00, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'h00, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'h00, 1'b1, 64'd0},
    // one-bit fields, eight elements from one byte
    '{1'b1, CfgElementBytes, 8'd1, 1'b0, 64'd0},
    '{1'b1, CfgFieldTopBit, 8'd0, 1'b0, 64'd0},
    '{1'b1, CfgFieldLength, 8'd1, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'hA5, 1'b0, 64'd0},
    // oversized element and length clamp to 8 bytes and 64 bits
    '{1'b1, CfgElementBytes, 8'd15, 1'b0, 64'd0},
    '{1'b1, CfgFieldTopBit, 8'd63, 1'b0, 64'd0},
    '{1'b1, CfgFieldLength, 8'd127, 1'b0, 64'd0},
    '{1'b1, CfgFillOnes, 8'd1, 1'b0, 64'd0},
    '{1'b1, CfgSignExtend, 8'd1, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'h80, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'h00, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'h00, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'h00, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'h00, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'h00, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'h00, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'h00, 1'b1, 64'h8000_0000_0000_0000},
    // field above the element, no sign extension
    '{1'b1, CfgElementBytes, 8'd1, 1'b0, 64'd0},
    '{1'b1, CfgFieldTopBit, 8'd40, 1'b0, 64'd0},
    '{1'b1, CfgFieldLength, 8'd8, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'h00, 1'b1, 64'h0000_0000_0000_00FF},
    // field falling below bit 0
    '{1'b1, CfgElementBytes, 8'd2, 1'b0, 64'd0},
    '{1'b1, CfgFieldTopBit, 8'd2, 1'b0, 64'd0},
    '{1'b1, CfgFillOnes, 8'd0, 1'b0, 64'd0},
    '{1'b1, CfgSignExtend, 8'd0, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'hFF, 1'b1, 64'h0000_0000_0000_0007},
    // zero element size and zero length act as one
    '{1'b1, CfgElementBytes, 8'd0, 1'b0, 64'd0},
    '{1'b1, CfgFieldTopBit, 8'd0, 1'b0, 64'd0},
    '{1'b1, CfgFieldLength, 8'd0, 1'b0, 64'd0},
    '{1'b1, CfgSignExtend, 8'd1, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'h81, 1'b0, 64'd0},
    // length lowered with bits already gathered
    '{1'b1, CfgElementBytes, 8'd2, 1'b0, 64'd0},
    '{1'b1, CfgFieldTopBit, 8'd11, 1'b0, 64'd0},
    '{1'b1, CfgFieldLength, 8'd12, 1'b0, 64'd0},
    '{1'b1, CfgSignExtend, 8'd0, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'hAB, 1'b0, 64'd0},
    '{1'b1, CfgFieldLength, 8'd4, 1'b0, 64'd0},
    '{1'b0, CfgElementBytes, 8'hCD, 1'b0, 64'd0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  nbu_chan_if #(.payload_t(in_item_t))  in_ch ();
  nbu_chan_if #(.payload_t(out_item_t)) out_ch ();

  nbit_field_unpacker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  logic [BytesW-1:0] cur_bytes = ResetElementBytes;
  logic [TopW-1:0]   cur_top   = ResetFieldTopBit;
  logic [LenW-1:0]   cur_len   = ResetFieldLength;
  logic              cur_fill  = 1'b0;
  logic              cur_sext  = 1'b0;

  logic [AccW-1:0]   gather_acc = '0;
  logic [HeldW-1:0]  gather_cnt = '0;

  feed_t     byte_q[$];
  out_item_t element_q[$];
  int        errors = 0;
  logic      jitter = 1'b1;
  int        hold_ticket = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] ones_below(int n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic logic [63:0] align_field(logic [63:0] v, int len, int top);
    int lo;
    lo = top - len + 1;
    if (lo >= 0) return v << lo;
    return v >> (-lo);
  endfunction

  function automatic logic [63:0] expand_field(logic [63:0] raw, int len);
    int          nbytes;
    int          width_bits;
    int          top;
    logic [63:0] val;
    logic [63:0] fmask;
    logic [63:0] elem;
    nbytes = (cur_bytes == 0) ? 1 :
             (cur_bytes > MaxElementBytes) ? MaxElementBytes : int'(cur_bytes);
    width_bits = nbytes * 8;
    top = int'(cur_top);
    val = raw & ones_below(len);
    fmask = align_field(ones_below(len), len, top);
    elem = cur_fill ? ~fmask : '0;
    elem |= align_field(val, len, top);
    if (cur_sext && top < width_bits) begin
      if (val[len-1]) elem |= ~ones_below(top);
      else elem &= ones_below(top);
    end
    return elem & ones_below(width_bits);
  endfunction

  task automatic unpack_byte(feed_t it);
    int          len;
    int          held;
    int          n;
    int          i;
    logic [63:0] acc;
    logic [63:0] found[8];
    out_item_t   x;
    len = (cur_len == 0) ? 1 : (cur_len > MaxFieldLength) ? 64 : int'(cur_len);
    acc = {1'b0, gather_acc};
    held = int'(gather_cnt);
    n = 0;
    for (i = 7; i >= 0; i--) begin
      acc = {acc[62:0], it.value[i]};
      held++;
      if (held >= len) begin
        found[n] = expand_field(acc, len);
        n++;
        acc = '0;
        held = 0;
      end
    end
    gather_acc = acc[AccW-1:0];
    gather_cnt = held[HeldW-1:0];
    if (it.typed) begin
      x.element_value = it.want;
      x.last_of_byte = 1'b1;
      element_q.push_back(x);
    end else begin
      for (i = 0; i < n; i++) begin
        x.element_value = found[i];
        x.last_of_byte = (i == n - 1);
        element_q.push_back(x);
      end
    end
  endtask

  task automatic await_quiet(int settle);
    while (byte_q.size() != 0 || in_ch.valid || element_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic program_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    await_quiet(4);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CfgElementBytes: cur_bytes = data[BytesW-1:0];
      CfgFieldTopBit:  cur_top = data[TopW-1:0];
      CfgFieldLength:  cur_len = data[LenW-1:0];
      CfgFillOnes:     cur_fill = data[0];
      CfgSignExtend:   cur_sext = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // input side: offer bytes, predict on each accepted transaction
  initial begin : feed
    feed_t offered;
    int    gap;
    logic  took;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    offered = '0;
    gap = 0;
    forever begin
      @(posedge clk_i);
      took = in_ch.valid && in_ch.ready;
      if (took) unpack_byte(offered);
      @(negedge clk_i);
      if (took || !in_ch.valid) begin
        if (gap > 0) begin
          gap--;
          in_ch.valid <= 1'b0;
        end else if (byte_q.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (jitter && $urandom_range(0, 5) == 0) begin
          gap = $urandom_range(0, 5);
          in_ch.valid <= 1'b0;
        end else begin
          offered = byte_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.data.stream_byte <= offered.value;
        end
      end
    end
  end

  // output side: random stalls, plus a long hold-off on request
  initial begin : drain
    int hold;
    int stall;
    int served;
    out_ch.ready = 1'b0;
    hold = 0;
    stall = 0;
    served = 0;
    forever begin
      @(negedge clk_i);
      if (served != hold_ticket) begin
        served = hold_ticket;
        hold = 80;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (jitter && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : check
    out_item_t want;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        if (element_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got element %h last %b",
                   $time, out_ch.data.element_value, out_ch.data.last_of_byte);
          errors++;
        end else begin
          want = element_q.pop_front();
          if (out_ch.data.element_value !== want.element_value) begin
            $display("%0t: element_value expected %h got %h",
                     $time, want.element_value, out_ch.data.element_value);
            errors++;
          end
          if (out_ch.data.last_of_byte !== want.last_of_byte) begin
            $display("%0t: last_of_byte expected %b got %b",
                     $time, want.last_of_byte, out_ch.data.last_of_byte);
            errors++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    repeat (Limit) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : main
    int    r;
    int    phase;
    int    k;
    int    len_v;
    int    bytes_v;
    int    top_v;
    feed_t item;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (r = 0; r < PlanLen; r++) begin
      if (Plan[r].is_cfg) begin
        program_reg(Plan[r].idx, Plan[r].val[CfgDataW-1:0]);
      end else begin
        item.value = Plan[r].val;
        item.typed = Plan[r].typed;
        item.want = Plan[r].want;
        byte_q.push_back(item);
      end
    end

    for (phase = 0; phase < RandPhases; phase++) begin
      bytes_v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
      top_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 63);
      if ($urandom_range(0, 4) == 0) len_v = $urandom_range(0, 127);
      else len_v = $urandom_range(1, 24);
      if (phase == 0) len_v = $urandom_range(1, 3);
      if (phase == 1) begin
        bytes_v = 8;
        top_v = 63;
        len_v = 64;
      end
      program_reg(CfgElementBytes, 7'(bytes_v));
      program_reg(CfgFieldTopBit, 7'(top_v));
      program_reg(CfgFieldLength, 7'(len_v));
      program_reg(CfgFillOnes, 7'($urandom_range(0, 1)));
      program_reg(CfgSignExtend, 7'($urandom_range(0, 1)));
      jitter = (phase < RandPhases - 2) && (phase % 3 != 2);
      // fill the block up while the receiver holds off
      if (phase == 0) hold_ticket++;
      for (k = 0; k < BytesPerPhase; k++) begin
        case ($urandom_range(0, 7))
          0: item.value = 8'h00;
          1: item.value = 8'hFF;
          default: item.value = 8'($urandom_range(0, 255));
        endcase
        item.typed = 1'b0;
        item.want = '0;
        byte_q.push_back(item);
      end
    end

    await_quiet(20);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/nbu_pkg.sv
sv/nbu_chan_if.sv
sv/nbu_cfg_regs.sv
sv/nbu_gather.sv
sv/nbu_elem_build.sv
sv/nbit_field_unpacker.sv
tb/nbit_field_unpacker_tb.sv
